[rtl/u8bd_pkg.sv]
package u8bd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] MASK_E0 = 8'hE0;
    localparam logic [7:0] MASK_F0 = 8'hF0;
    localparam logic [7:0] MASK_F8 = 8'hF8;
    localparam logic [7:0] CODE_C0 = 8'hC0;
    localparam logic [7:0] CODE_E0 = 8'hE0;
    localparam logic [7:0] CODE_F0 = 8'hF0;
    localparam logic [7:0] MASK_3F = 8'h3F;
    localparam logic [7:0] MASK_1F = 8'h1F;
    localparam logic [7:0] MASK_0F = 8'h0F;
    localparam logic [7:0] MASK_07 = 8'h07;

    localparam logic [20:0] CP_PRINT_LO  = 21'd33;
    localparam logic [20:0] CP_PRINT_HI  = 21'd126;
    localparam logic [20:0] CP_LATIN_LO  = 21'd161;
    localparam logic [20:0] CP_LATIN_MID = 21'd172;
    localparam logic [20:0] CP_LATIN_RE  = 21'd174;
    localparam logic [20:0] CP_LATIN_HI  = 21'd255;
    localparam logic [20:0] CP_SHIFT_LO  = 21'd256;
    localparam logic [20:0] CP_SHIFT_HI  = 21'd323;

    localparam logic [6:0] K_LOW_END  = 7'd33;
    localparam logic [6:0] K_HIGH_END = 7'd67;
    localparam logic [7:0] K_HIGH_OFS = 8'd94;
    localparam logic [7:0] BYTE_SHY   = 8'd173;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic seq_open;
    } front_status_t;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if (!c[7]) begin
            len = 3'd1;
        end else if ((c & MASK_E0) == CODE_C0) begin
            len = 3'd2;
        end else if ((c & MASK_F0) == CODE_E0) begin
            len = 3'd3;
        end else if ((c & MASK_F8) == CODE_F0) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

endpackage

[rtl/u8bd_front.sv]
module u8bd_front
    import u8bd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_t           s_data,
    input  queue_status_t q_status,
    output logic          run_push,
    output run_t          run_data,
    output front_status_t front_status
);

    logic [7:0] held_bytes_reg [0:2];
    logic [1:0] held_count_reg, held_count_next;
    logic [1:0] seq_len_reg, seq_len_next;

    logic       accept;
    logic       seq_open;
    logic [1:0] h;
    logic [2:0] n;
    logic [7:0] lead;
    logic [2:0] need;
    logic       hold;
    logic [1:0] wr_idx;

    assign s_ready  = !q_status.full;
    assign accept   = s_valid && s_ready;
    assign seq_open = (seq_len_reg != 2'd0);
    assign h        = seq_open ? held_count_reg : 2'd0;
    assign n        = {1'b0, h} + 3'd1;
    assign lead     = seq_open ? held_bytes_reg[0] : s_data.in_byte;
    assign need     = lead_length(lead);
    assign hold     = !s_data.stream_end && (n < need);
    assign wr_idx   = seq_open ? held_count_reg : 2'd0;
    assign run_push = accept && !hold;

    assign front_status.seq_open = seq_open;

    always_comb begin
        run_data.bytes[0] = (h == 2'd0) ? s_data.in_byte : held_bytes_reg[0];
        run_data.bytes[1] = (h > 2'd1) ? held_bytes_reg[1] : s_data.in_byte;
        run_data.bytes[2] = (h > 2'd2) ? held_bytes_reg[2] : s_data.in_byte;
        run_data.bytes[3] = s_data.in_byte;
        run_data.last_idx = h;
    end

    always_comb begin
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        if (accept) begin
            if (hold) begin
                if (!seq_open) begin
                    seq_len_next = 2'(need - 3'd1);
                end
                held_count_next = wr_idx + 2'd1;
            end else begin
                held_count_next = 2'd0;
                seq_len_next    = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= 2'd0;
        end else begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && hold) begin
            held_bytes_reg[wr_idx] <= s_data.in_byte;
        end
    end

endmodule

[rtl/u8bd_queue.sv]
module u8bd_queue
    import u8bd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  run_t          push_data,
    input  logic          pop,
    output run_t          head_data,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_t             mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/u8bd_back.sv]
module u8bd_back
    import u8bd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  run_t          head_data,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output out_t          m_data
);

    logic [3:0][7:0] buf_reg;
    logic [1:0]      last_idx_reg;
    logic [1:0]      pos_reg, pos_next;
    logic [1:0]      raw_reg, raw_next;
    logic            busy_reg, busy_next;
    logic            m_valid_reg, m_valid_next;
    out_t            m_data_reg, m_data_next;

    logic            advance;
    logic            step_last;
    logic [7:0]      c, b1, b2, b3;
    logic [2:0]      len;
    logic [2:0]      adv;
    logic [2:0]      new_pos;
    logic [20:0]     cp;
    logic            mapped;
    logic [7:0]      mapped_byte;
    logic [7:0]      step_byte;
    logic [6:0]      k;

    assign c  = buf_reg[pos_reg];
    assign b1 = buf_reg[pos_reg + 2'd1];
    assign b2 = buf_reg[pos_reg + 2'd2];
    assign b3 = buf_reg[pos_reg + 2'd3];

    always_comb begin
        len = lead_length(c);
        cp  = '0;
        if (len == 3'd1) begin
            cp = c[7] ? 21'd0 : {13'd0, c};
        end else if (({1'b0, pos_reg} + len - 3'd1) <= {1'b0, last_idx_reg}) begin
            case (len)
                3'd2: cp = {10'd0, 5'(c & MASK_1F), 6'(b1 & MASK_3F)};
                3'd3: cp = {5'd0, 4'(c & MASK_0F), 6'(b1 & MASK_3F), 6'(b2 & MASK_3F)};
                3'd4: cp = {3'(c & MASK_07), 6'(b1 & MASK_3F), 6'(b2 & MASK_3F),
                            6'(b3 & MASK_3F)};
                default: cp = '0;
            endcase
        end else begin
            len = 3'd1;
            cp  = '0;
        end
    end

    always_comb begin
        k           = cp[6:0];
        mapped      = 1'b0;
        mapped_byte = cp[7:0];
        if ((cp >= CP_PRINT_LO && cp <= CP_PRINT_HI) ||
            (cp >= CP_LATIN_LO && cp <= CP_LATIN_MID) ||
            (cp >= CP_LATIN_RE && cp <= CP_LATIN_HI)) begin
            mapped = 1'b1;
        end else if (cp >= CP_SHIFT_LO && cp <= CP_SHIFT_HI) begin
            mapped = 1'b1;
            if (k < K_LOW_END) begin
                mapped_byte = {1'b0, k};
            end else if (k < K_HIGH_END) begin
                mapped_byte = {1'b0, k} + K_HIGH_OFS;
            end else begin
                mapped_byte = BYTE_SHY;
            end
        end
    end

    always_comb begin
        if (raw_reg != 2'd0) begin
            step_byte = c;
            adv       = 3'd1;
            raw_next  = raw_reg - 2'd1;
        end else if (mapped) begin
            step_byte = mapped_byte;
            adv       = len;
            raw_next  = 2'd0;
        end else begin
            step_byte = c;
            adv       = 3'd1;
            raw_next  = 2'(len - 3'd1);
        end
        new_pos   = {1'b0, pos_reg} + adv;
        step_last = (new_pos == ({1'b0, last_idx_reg} + 3'd1));
        pos_next  = new_pos[1:0];
    end

    assign advance = busy_reg && (!m_valid_reg || m_ready);
    assign pop     = !q_status.empty && (!busy_reg || (advance && step_last));

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = step_byte;
            m_data_next.run_last = step_last;
            if (step_last) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            pos_reg     <= 2'd0;
            raw_reg     <= 2'd0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            if (pop) begin
                pos_reg <= 2'd0;
                raw_reg <= 2'd0;
            end else if (advance) begin
                pos_reg <= pos_next;
                raw_reg <= raw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (pop) begin
            buf_reg      <= head_data.bytes;
            last_idx_reg <= head_data.last_idx;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/utf8_to_byte_level_decoder_unit.sv]
// Channel   Direction  Ports                       Payload
// input     in         s_valid s_ready s_data      in_t  (in_byte, stream_end)
// result    out        m_valid m_ready m_data      out_t (out_byte, run_last)
//
// One input byte is taken per cycle while the run queue has room.
// The back end emits the result bytes of a run one at a time and holds while results
// stall; a sequence of n bytes gives n bytes at most and a single byte when it maps.
// Reset clears the open sequence, the queue and the output valid flag.
// The queue lets the input side keep taking transactions while results stall.
module utf8_to_byte_level_decoder_unit
    import u8bd_pkg::*;
#(
    parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    queue_status_t q_status;
    front_status_t front_status;
    logic          run_push;
    run_t          run_data;
    logic          run_pop;
    run_t          head_data;

    u8bd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .q_status     (q_status),
        .run_push     (run_push),
        .run_data     (run_data),
        .front_status (front_status)
    );

    u8bd_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (run_push),
        .push_data (run_data),
        .pop       (run_pop),
        .head_data (head_data),
        .status    (q_status)
    );

    u8bd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_data (head_data),
        .q_status  (q_status),
        .pop       (run_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(run_push && q_status.full))
        else $error("Run pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(run_pop && q_status.empty))
        else $error("Run popped from an empty queue.");

    a_end_flushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.stream_end) |-> run_push)
        else $error("End of stream did not flush the open sequence.");

    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.stream_end) |=> !front_status.seq_open)
        else $error("Sequence still open after end of stream.");

endmodule
